### design/knc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// knc_pkg
// Shared constants and controller/datapath interface types for the k-nearest
// neighbor match consistency filter.
// ----------------------------------------------------------------------------
package knc_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_POINTS_DEFAULT = 64;
   localparam int COORD_BITS_DEFAULT = 12;

   // Fixed field widths
   localparam int IN_COORD_BITS  = 12;
   localparam int THRESHOLD_BITS = 17;
   localparam int NEIGHBOR_BITS  = 6;
   localparam int INDEX_OUT_BITS = 6;
   localparam int FRAC_BITS      = 16;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEIGHBORS = 1'd1;

   // Register reset values
   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 17'd32768;
   localparam logic [NEIGHBOR_BITS-1:0]  NEIGHBORS_RESET = 6'd8;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_item;     // store the incoming request
      logic start_pair;    // clear neighbor sets for the current pair
      logic fetch_own;     // read the current pair's own point
      logic capture_own;   // latch the own point
      logic scan_start;    // restart the scan and the best candidate
      logic scan_issue;    // issue one scan read
      logic mark;          // commit the best candidate of the round
      logic phase_b_start; // switch to image B
      logic emit;          // load the result register
      logic next_pair;     // advance to the next pair
      logic clear_set;     // empty the set
   } knc_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic                     keff_zero;
      logic                     scan_last;
      logic                     pipe_empty;
      logic                     round_last;
      logic                     pair_last;
      logic                     phase_b;
      logic                     rsp_free;
      logic [NEIGHBOR_BITS-1:0] keff;
   } knc_status_type;

endpackage
`default_nettype wire

### design/knc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// knc_datapath
// Point memories, distance pipeline, nearest-candidate tracking, neighbor sets,
// shared counter, configuration registers and the result register.
// ----------------------------------------------------------------------------
module knc_datapath
   import knc_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT,
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire knc_cmd_type               cmd,
   output knc_status_type                 status,
   input  wire logic [IN_COORD_BITS-1:0]  req_a_x,
   input  wire logic [IN_COORD_BITS-1:0]  req_a_y,
   input  wire logic [IN_COORD_BITS-1:0]  req_b_x,
   input  wire logic [IN_COORD_BITS-1:0]  req_b_y,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [THRESHOLD_BITS-1:0] csr_write_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [INDEX_OUT_BITS-1:0]      rsp_pair_index,
   output logic [NEIGHBOR_BITS-1:0]       rsp_shared_count,
   output logic                           rsp_consistent,
   output logic                           rsp_overflowed,
   output logic                           rsp_last_result
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int KW = (CW > NEIGHBOR_BITS) ? CW : NEIGHBOR_BITS;
   localparam int PW = 2 * COORD_BITS;
   localparam int DW = 2 * COORD_BITS + 1;
   localparam int MW = THRESHOLD_BITS + NEIGHBOR_BITS;

   // Point memories, x above y
   logic [PW-1:0] a_mem_ff [MAX_POINTS];
   logic [PW-1:0] b_mem_ff [MAX_POINTS];
   logic [PW-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0] rd_addr;

   logic [THRESHOLD_BITS-1:0] thr_ff, thr_in;
   logic [NEIGHBOR_BITS-1:0]  nc_ff, nc_in;
   logic [CW-1:0]             loaded_ff, loaded_in;
   logic                      dropped_ff, dropped_in;
   logic [AW-1:0]             pair_ff, pair_in;
   logic [AW-1:0]             scan_ff, scan_in;
   logic [NEIGHBOR_BITS-1:0]  round_ff, round_in;
   logic                      phase_ff, phase_in;
   logic [PW-1:0]             own_ff, own_in;
   logic [MAX_POINTS-1:0]     sel_a_ff, sel_a_in, sel_b_ff, sel_b_in;
   logic [NEIGHBOR_BITS-1:0]  shared_ff, shared_in;

   // Distance pipeline
   logic                  v_rd_ff, v_d_ff, v_sq_ff;
   logic [AW-1:0]         j_rd_ff, j_d_ff, j_sq_ff;
   logic [COORD_BITS-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [PW-1:0]         sqx_ff, sqy_ff;
   logic                  found_ff, found_in;
   logic [AW-1:0]         best_ff, best_in;
   logic [DW-1:0]         best_d_ff, best_d_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [INDEX_OUT_BITS-1:0] rsp_index_ff;
   logic [NEIGHBOR_BITS-1:0]  rsp_shared_ff;
   logic                  rsp_cons_ff, rsp_ovf_ff, rsp_last_ff;

   logic [PW-1:0]         cur_pt;
   logic [PW-1:0]         wr_a, wr_b;
   logic [COORD_BITS-1:0] px, py, qx, qy;
   logic [DW-1:0]         cand_dist;
   logic                  cand_ok;
   logic                  full;
   logic [CW-1:0]         loaded_m1;
   logic [KW-1:0]         keff_wide;
   logic [NEIGHBOR_BITS-1:0] keff;
   logic [MW-1:0]         lhs, rhs;
   logic                  pair_last;

   assign full      = (loaded_ff == CW'(MAX_POINTS));
   assign loaded_m1 = (loaded_ff == '0) ? '0 : loaded_ff - CW'(1);
   assign keff_wide = (KW'(nc_ff) > KW'(loaded_m1)) ? KW'(loaded_m1) : KW'(nc_ff);
   assign keff      = NEIGHBOR_BITS'(keff_wide);
   assign pair_last = (CW'(pair_ff) + CW'(1) == loaded_ff);

   assign wr_a = {COORD_BITS'(req_a_x), COORD_BITS'(req_a_y)};
   assign wr_b = {COORD_BITS'(req_b_x), COORD_BITS'(req_b_y)};

   // Store requests and read one address a cycle
   assign rd_addr = cmd.fetch_own ? pair_ff : scan_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_item && !full) begin
         a_mem_ff[loaded_ff[AW-1:0]] <= wr_a;
         b_mem_ff[loaded_ff[AW-1:0]] <= wr_b;
      end
      rd_a_ff <= a_mem_ff[rd_addr];
      rd_b_ff <= b_mem_ff[rd_addr];
   end

   assign cur_pt = phase_ff ? rd_b_ff : rd_a_ff;

   // Absolute coordinate differences
   assign px = own_ff[PW-1:COORD_BITS];
   assign py = own_ff[COORD_BITS-1:0];
   assign qx = cur_pt[PW-1:COORD_BITS];
   assign qy = cur_pt[COORD_BITS-1:0];
   assign dx_in = (px > qx) ? px - qx : qx - px;
   assign dy_in = (py > qy) ? py - qy : qy - py;

   // Candidate compare, skipping the own point and points already picked
   assign cand_dist = DW'(sqx_ff) + DW'(sqy_ff);
   assign cand_ok   = v_sq_ff && (j_sq_ff != pair_ff) &&
                      !(phase_ff ? sel_b_ff[j_sq_ff] : sel_a_ff[j_sq_ff]);

   always_comb begin
      found_in  = found_ff;
      best_in   = best_ff;
      best_d_in = best_d_ff;
      if (cmd.scan_start) begin
         found_in = 1'b0;
      end else if (cand_ok && (!found_ff || cand_dist < best_d_ff)) begin
         found_in  = 1'b1;
         best_in   = j_sq_ff;
         best_d_in = cand_dist;
      end
   end

   // Set bookkeeping and configuration
   always_comb begin
      thr_in     = thr_ff;
      nc_in      = nc_ff;
      loaded_in  = loaded_ff;
      dropped_in = dropped_ff;
      pair_in    = pair_ff;
      scan_in    = scan_ff;
      round_in   = round_ff;
      phase_in   = phase_ff;
      own_in     = own_ff;
      sel_a_in   = sel_a_ff;
      sel_b_in   = sel_b_ff;
      shared_in  = shared_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_THRESHOLD: thr_in = csr_write_data;
            CSR_NEIGHBORS: nc_in  = csr_write_data[NEIGHBOR_BITS-1:0];
            default: ;
         endcase
      end
      if (cmd.load_item) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            loaded_in = loaded_ff + CW'(1);
         end
      end
      if (cmd.start_pair) begin
         sel_a_in  = '0;
         sel_b_in  = '0;
         shared_in = '0;
         round_in  = '0;
         phase_in  = 1'b0;
      end
      if (cmd.capture_own) begin
         own_in = cur_pt;
      end
      if (cmd.scan_start) begin
         scan_in = '0;
      end else if (cmd.scan_issue) begin
         scan_in = scan_ff + AW'(1);
      end
      if (cmd.mark) begin
         round_in = round_ff + NEIGHBOR_BITS'(1);
         if (found_ff) begin
            if (phase_ff) begin
               sel_b_in[best_ff] = 1'b1;
               if (sel_a_ff[best_ff]) begin
                  shared_in = shared_ff + NEIGHBOR_BITS'(1);
               end
            end else begin
               sel_a_in[best_ff] = 1'b1;
            end
         end
      end
      if (cmd.phase_b_start) begin
         phase_in = 1'b1;
         round_in = '0;
      end
      if (cmd.next_pair) begin
         pair_in = pair_ff + AW'(1);
      end
      if (cmd.clear_set) begin
         loaded_in  = '0;
         dropped_in = 1'b0;
         pair_in    = '0;
      end
   end

   // Consistency test: shared * 65536 >= threshold * K
   assign lhs = MW'({shared_ff, FRAC_BITS'(0)});
   assign rhs = MW'(thr_ff) * MW'(keff);

   // Hold the result until taken
   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THRESHOLD_RESET;
         nc_ff        <= NEIGHBORS_RESET;
         loaded_ff    <= '0;
         dropped_ff   <= 1'b0;
         pair_ff      <= '0;
         v_rd_ff      <= 1'b0;
         v_d_ff       <= 1'b0;
         v_sq_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         nc_ff        <= nc_in;
         loaded_ff    <= loaded_in;
         dropped_ff   <= dropped_in;
         pair_ff      <= pair_in;
         v_rd_ff      <= cmd.scan_issue;
         v_d_ff       <= v_rd_ff;
         v_sq_ff      <= v_d_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      round_ff  <= round_in;
      phase_ff  <= phase_in;
      own_ff    <= own_in;
      sel_a_ff  <= sel_a_in;
      sel_b_ff  <= sel_b_in;
      shared_ff <= shared_in;
      found_ff  <= found_in;
      best_ff   <= best_in;
      best_d_ff <= best_d_in;
      j_rd_ff   <= scan_ff;
      j_d_ff    <= j_rd_ff;
      j_sq_ff   <= j_d_ff;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      sqx_ff    <= PW'(dx_ff) * PW'(dx_ff);
      sqy_ff    <= PW'(dy_ff) * PW'(dy_ff);
      if (cmd.emit) begin
         rsp_index_ff  <= INDEX_OUT_BITS'(pair_ff);
         rsp_shared_ff <= shared_ff;
         rsp_cons_ff   <= (lhs >= rhs);
         rsp_ovf_ff    <= dropped_ff;
         rsp_last_ff   <= pair_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pair_index   = rsp_index_ff;
   assign rsp_shared_count = rsp_shared_ff;
   assign rsp_consistent   = rsp_cons_ff;
   assign rsp_overflowed   = rsp_ovf_ff;
   assign rsp_last_result  = rsp_last_ff;

   assign status.keff_zero  = (keff == '0);
   assign status.scan_last  = (CW'(scan_ff) + CW'(1) == loaded_ff);
   assign status.pipe_empty = !v_rd_ff && !v_d_ff && !v_sq_ff;
   assign status.round_last = (round_ff + NEIGHBOR_BITS'(1) == keff);
   assign status.pair_last  = pair_last;
   assign status.phase_b    = phase_ff;
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign status.keff       = keff;

endmodule
`default_nettype wire

### design/knc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// knc_ctrl
// Sequencer: loads the set, then for each pair runs K nearest-point rounds in
// image A and in image B and emits one result.
// ----------------------------------------------------------------------------
module knc_ctrl
   import knc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_last_pair,
   output logic                req_stall,
   input  wire knc_status_type status,
   output knc_cmd_type         cmd
);

   localparam logic [2:0] ST_LOAD   = 3'd0;
   localparam logic [2:0] ST_PAIR   = 3'd1;
   localparam logic [2:0] ST_OWN    = 3'd2;
   localparam logic [2:0] ST_OWNCAP = 3'd3;
   localparam logic [2:0] ST_SCAN   = 3'd4;
   localparam logic [2:0] ST_DRAIN  = 3'd5;
   localparam logic [2:0] ST_MARK   = 3'd6;
   localparam logic [2:0] ST_EMIT   = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_LOAD);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               if (req_last_pair) begin
                  state_in = ST_PAIR;
               end
            end
         end
         ST_PAIR: begin
            cmd.start_pair = 1'b1;
            state_in = status.keff_zero ? ST_EMIT : ST_OWN;
         end
         ST_OWN: begin
            cmd.fetch_own = 1'b1;
            state_in = ST_OWNCAP;
         end
         ST_OWNCAP: begin
            cmd.capture_own = 1'b1;
            cmd.scan_start  = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.pipe_empty) begin
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            cmd.mark = 1'b1;
            if (!status.round_last) begin
               cmd.scan_start = 1'b1;
               state_in = ST_SCAN;
            end else if (status.phase_b) begin
               state_in = ST_EMIT;
            end else begin
               cmd.phase_b_start = 1'b1;
               state_in = ST_OWN;
            end
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               if (status.pair_last) begin
                  cmd.clear_set = 1'b1;
                  state_in = ST_LOAD;
               end else begin
                  cmd.next_pair = 1'b1;
                  state_in = ST_PAIR;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### design/knn_neighborhood_consistency_filter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// knn_neighborhood_consistency_filter_core
// Checks matched point pairs for agreement of their K-nearest neighborhoods.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel loads one matched pair (A point, B point) per request,
//   one per cycle while loading. A request with req_last_pair closes the set
//   and starts evaluation; req_stall stays high until the last result of the
//   set has been loaded into the output register. Pairs beyond MAX_POINTS are
//   dropped and reported through rsp_overflowed.
//   The rsp_ channel then gives one result per stored pair in load order,
//   rsp_last_result on the final one. A stalled result holds in the output
//   register, and the next result is not loaded until it is taken.
//   Per pair the distance unit scans all n stored points once per neighbor
//   round, K rounds in image A and K in image B, K = min(neighbor_count,
//   n-1). The point memories read one address per cycle and feed the
//   read, difference and square stages of the distance pipeline.
//   csr_ writes take effect on the next cycle; write only while idle.
//   Synchronous reset returns to loading with an empty set, the threshold at
//   one half and K at 8. Point memories are not cleared.
// ----------------------------------------------------------------------------
module knn_neighborhood_consistency_filter_core
   import knc_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT,
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [IN_COORD_BITS-1:0]  req_a_x,
   input  wire logic [IN_COORD_BITS-1:0]  req_a_y,
   input  wire logic [IN_COORD_BITS-1:0]  req_b_x,
   input  wire logic [IN_COORD_BITS-1:0]  req_b_y,
   input  wire logic                      req_last_pair,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [INDEX_OUT_BITS-1:0]      rsp_pair_index,
   output logic [NEIGHBOR_BITS-1:0]       rsp_shared_count,
   output logic                           rsp_consistent,
   output logic                           rsp_overflowed,
   output logic                           rsp_last_result,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [THRESHOLD_BITS-1:0] csr_write_data
);

   knc_cmd_type    cmd;
   knc_status_type status;

   knc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_pair (req_last_pair),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   knc_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_a_x          (req_a_x),
      .req_a_y          (req_a_y),
      .req_b_x          (req_b_x),
      .req_b_y          (req_b_y),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pair_index   (rsp_pair_index),
      .rsp_shared_count (rsp_shared_count),
      .rsp_consistent   (rsp_consistent),
      .rsp_overflowed   (rsp_overflowed),
      .rsp_last_result  (rsp_last_result)
   );

`ifndef NO_ASSERTIONS
   // Closing a set stops further requests
   a_last_closes_set: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_pair |=> req_stall)
      else $error("request accepted right after last pair");

   // No request is taken while a set still has results to give
   a_no_load_mid_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> req_stall)
      else $error("request accepted during evaluation");

   // Shared count never exceeds the effective neighbor count
   a_shared_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (rsp_shared_count <= $past(status.keff)))
      else $error("shared count above effective K");

   // A result is loaded only into a free output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.rsp_free)
      else $error("result overwritten");
`endif

endmodule
`default_nettype wire
